// ===== rtl/dmm_pkg.sv =====
// Shared types, constants and helpers of the dense matrix multiplier.
`timescale 1ns / 1ps

package dmm_pkg;

  // Largest matrix dimension supported by default.
  localparam int unsigned MAX_DIM_DEF = 8;

  // Accumulator width; products are added after the Q16.16 realignment.
  localparam int unsigned ACC_W = 48;

  // Reset value of every dimension register.
  localparam logic [3:0] DIM_RESET = 4'd4;

  // Item operation codes.
  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_MUL    = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] out_value;
    logic               saturated;
    logic               last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_OUT
  } state_e;

  // Last valid index for a dimension register: zero counts as one, values
  // above the supported maximum are clamped to it.
  function automatic logic [3:0] eff_last(logic [3:0] cfg, logic [3:0] max_dim);
    logic [3:0] res;
    if (cfg == 4'd0) begin
      res = 4'd0;
    end else if (cfg > max_dim) begin
      res = max_dim - 4'd1;
    end else begin
      res = cfg - 4'd1;
    end
    return res;
  endfunction

endpackage

// ===== rtl/dmm_stream_if.sv =====
// Valid/ready stream interfaces for the input items and the result items.
`timescale 1ns / 1ps

interface dmm_in_if;
  logic               valid;
  logic               ready;
  dmm_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface dmm_out_if;
  logic               valid;
  logic               ready;
  dmm_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/dmm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module dmm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dense_matrix_multiply.sv =====
// Top level of the dense matrix multiplier, C = A x B in signed Q16.16.
`timescale 1ns / 1ps

// Usage
// The input channel carries one item per transfer. An item with func 0 or 1
// writes one element of A or B into an on-chip RAM; the
// block stays ready for the next item. Writes with row or col beyond the
// supported dimension are dropped, and func 3 is consumed with no effect.
// An item with func 2 starts the product. The dimensions come from the
// rows_a, inner_dim and cols_b registers on the APB port (zero acts as one,
// values above MAX_DIM act as MAX_DIM). The elements of C leave on the output
// channel in row-major order, the last one flagged.
// Each element is built by a single shared multiply-accumulate unit: one
// read of both RAMs per cycle, a registered 32x32 multiplier and a 48-bit
// accumulator. The sequencer walks the inner dimension in ST_MAC, waits
// in ST_DRAIN until the pipeline is empty and offers the element in ST_OUT.
// The input is not ready while a product is in progress. A stalled
// receiver simply holds the offered element in the output register and
// the sequencer waits on it.
// Reset restores the dimension registers to 4 and returns the sequencer to
// idle; the RAM contents are undefined until written.

module dense_matrix_multiply #(
  parameter int unsigned MAX_DIM = dmm_pkg::MAX_DIM_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dmm_in_if.sink            in_i,
  dmm_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned CntW  = $clog2(MAX_DIM);
  localparam int unsigned Depth = MAX_DIM * MAX_DIM;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [3:0]  MaxDimW = 4'(MAX_DIM);

  // Configuration registers.
  logic [3:0] rows_a_q, inner_dim_q, cols_b_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= dmm_pkg::DIM_RESET;
      inner_dim_q <= dmm_pkg::DIM_RESET;
      cols_b_q    <= dmm_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (paddr[3:2])
        dmm_pkg::REG_ROWS_A:    rows_a_q    <= pwdata[3:0];
        dmm_pkg::REG_INNER_DIM: inner_dim_q <= pwdata[3:0];
        dmm_pkg::REG_COLS_B:    cols_b_q    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dmm_pkg::REG_ROWS_A:    prdata = {28'd0, rows_a_q};
      dmm_pkg::REG_INNER_DIM: prdata = {28'd0, inner_dim_q};
      dmm_pkg::REG_COLS_B:    prdata = {28'd0, cols_b_q};
      default:                prdata = 32'd0;
    endcase
  end

  // Effective last index of each loop.
  logic [3:0]      nr_full, nk_full, nc_full;
  logic [CntW-1:0] nr_last, nk_last, nc_last;

  assign nr_full = dmm_pkg::eff_last(rows_a_q, MaxDimW);
  assign nk_full = dmm_pkg::eff_last(inner_dim_q, MaxDimW);
  assign nc_full = dmm_pkg::eff_last(cols_b_q, MaxDimW);
  assign nr_last = nr_full[CntW-1:0];
  assign nk_last = nk_full[CntW-1:0];
  assign nc_last = nc_full[CntW-1:0];

  // Sequencer.
  dmm_pkg::state_e state_q, state_d;
  logic            in_xfer, out_xfer, issue, drained, elem_last;
  logic            v1_q, v2_q;
  logic [CntW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;

  assign in_xfer   = in_i.valid && in_i.ready;
  assign out_xfer  = out_o.valid && out_o.ready;
  assign drained   = !v1_q && !v2_q;
  assign elem_last = (i_q == nr_last) && (j_q == nc_last);

  always_comb begin
    state_d = state_q;
    case (state_q)
      dmm_pkg::ST_IDLE: begin
        if (in_xfer && in_i.payload.func == dmm_pkg::FUNC_MUL) begin
          state_d = dmm_pkg::ST_MAC;
        end
      end
      dmm_pkg::ST_MAC: begin
        if (k_q == nk_last) begin
          state_d = dmm_pkg::ST_DRAIN;
        end
      end
      dmm_pkg::ST_DRAIN: begin
        if (drained) begin
          state_d = dmm_pkg::ST_OUT;
        end
      end
      dmm_pkg::ST_OUT: begin
        if (out_xfer) begin
          state_d = elem_last ? dmm_pkg::ST_IDLE : dmm_pkg::ST_MAC;
        end
      end
      default: state_d = dmm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;
    issue       = 1'b0;
    case (state_q)
      dmm_pkg::ST_IDLE: in_i.ready  = 1'b1;
      dmm_pkg::ST_MAC:  issue       = 1'b1;
      dmm_pkg::ST_OUT:  out_o.valid = 1'b1;
      default: ;
    endcase
  end

  // Loop counters: k walks the inner dimension, j the columns, i the rows.
  always_comb begin
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    if (in_xfer && in_i.payload.func == dmm_pkg::FUNC_MUL) begin
      i_d = '0;
      j_d = '0;
      k_d = '0;
    end else if (issue) begin
      k_d = k_q + CntW'(1);
    end else if (out_xfer) begin
      k_d = '0;
      if (j_q == nc_last) begin
        j_d = '0;
        i_d = i_q + CntW'(1);
      end else begin
        j_d = j_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmm_pkg::ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
    end
  end

  // Element stores. Loads write at row * MAX_DIM + col; the product reads
  // A[i][k] and B[k][j] together in each issue cycle.
  logic             wr_ok, we_a, we_b;
  logic [AddrW-1:0] waddr, raddr_a, raddr_b;
  logic [31:0]      rdata_a, rdata_b;

  assign wr_ok = in_xfer && (in_i.payload.row < MaxDimW[2:0] || MaxDimW[3])
                 && (in_i.payload.col < MaxDimW[2:0] || MaxDimW[3]);
  assign we_a  = wr_ok && in_i.payload.func == dmm_pkg::FUNC_LOAD_A;
  assign we_b  = wr_ok && in_i.payload.func == dmm_pkg::FUNC_LOAD_B;
  assign waddr = AddrW'(AddrW'(in_i.payload.row) * AddrW'(MAX_DIM)
                        + AddrW'(in_i.payload.col));
  assign raddr_a = AddrW'(AddrW'(i_q) * AddrW'(MAX_DIM) + AddrW'(k_q));
  assign raddr_b = AddrW'(AddrW'(k_q) * AddrW'(MAX_DIM) + AddrW'(j_q));

  dmm_ram #(
    .Width (32),
    .Depth (Depth)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (in_i.payload.value),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  dmm_ram #(
    .Width (32),
    .Depth (Depth)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (in_i.payload.value),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // Shared multiply-accumulate unit. The product is registered; the
  // accumulator then adds bits 63:16, which is the floor of the product
  // over 2^16 taken modulo 2^48.
  logic signed [63:0]              prod_q, prod_d;
  logic [dmm_pkg::ACC_W-1:0]       acc_q, acc_d;
  logic [dmm_pkg::ACC_W-32:0]      acc_hi;
  dmm_pkg::out_item_t              out_q, out_d;

  assign prod_d = $signed(rdata_a) * $signed(rdata_b);
  assign acc_hi = acc_q[dmm_pkg::ACC_W-1:31];

  always_comb begin
    acc_d = acc_q;
    if (state_q != dmm_pkg::ST_MAC && state_d == dmm_pkg::ST_MAC) begin
      acc_d = '0;
    end else if (v2_q) begin
      acc_d = acc_q + prod_q[63:16];
    end
  end

  // Saturate the accumulator to 32 bits when the element is finished.
  always_comb begin
    out_d = out_q;
    if (state_q == dmm_pkg::ST_DRAIN && drained) begin
      out_d.out_row = 3'(i_q);
      out_d.out_col = 3'(j_q);
      out_d.last    = elem_last;
      if ((&acc_hi) || !(|acc_hi)) begin
        out_d.out_value = acc_q[31:0];
        out_d.saturated = 1'b0;
      end else if (acc_q[dmm_pkg::ACC_W-1]) begin
        out_d.out_value = 32'sh8000_0000;
        out_d.saturated = 1'b1;
      end else begin
        out_d.out_value = 32'sh7fff_ffff;
        out_d.saturated = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
  end

  assign out_o.payload = out_q;

  // Assertions.
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input ready while a result is offered");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dmm_pkg::ST_IDLE) |-> (!v1_q && !v2_q))
    else $error("multiply pipeline busy while idle");

  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.payload.last) |-> elem_last)
    else $error("last flag on an element that is not final");

  a_mul_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.payload.func == dmm_pkg::FUNC_MUL)
      |=> (state_q == dmm_pkg::ST_MAC && k_q == '0 && i_q == '0 && j_q == '0))
    else $error("product did not start after a multiply transfer");

endmodule

// ===== tb/tb_dense_matrix_multiply.sv =====
// Self-checking testbench for the dense matrix multiplier.
`timescale 1ns / 1ps

// The bench loads elements of A and B through the input channel, starts
// products and checks every element of C that leaves the output channel.
// It keeps its own copy of both element stores and of the dimension
// registers. From these it works out the expected elements of C as soon as
// a product request is accepted.
//
// The run has two parts. A short directed plan comes first and runs at 1x1
// size, so that its results can be written down by hand. It covers the
// saturation limits, floor rounding of negative products, a dropped func 3
// item, a write to an unused register index and an accumulator that wraps.
// A random part follows. It steps through several dimension settings: the
// largest, zero, the lopsided shapes and random ones, mostly small. Each
// job writes random elements and then any element the product still needs.
// A product never reads an element that was not written. Each job ends with
// a product request. Both channels idle in random bursts, except in the
// last part of the run.

module tb_dense_matrix_multiply;
  import dmm_pkg::*;

  localparam int unsigned DIM           = MAX_DIM_DEF;
  localparam int unsigned HALF_PERIOD   = 5;
  localparam int unsigned RESET_CYCLES  = 5;
  localparam int unsigned ITEM_GOAL     = 350;
  // The last items of the run go out with no idling on either channel.
  localparam int unsigned TAIL_ITEMS    = 50;
  // Margin that lets loads settle before a register write, and that
  // covers the end of the run.
  localparam int unsigned SETTLE_CYCLES = 16;
  // Slowest correct run: about 100 products of 8x8x8, 64 elements each.
  // Each element may wait out a receiver stall, and every load may sit out
  // an idle gap on the input. The limit allows ten times that run.
  localparam longint unsigned LIMIT_NS  = 20_000_000;

  // func 3 is not an operation; the block consumes it and does nothing.
  localparam logic [1:0] FUNC_NOP   = 2'd3;
  // Register index with no register behind it.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam logic signed [47:0] SAT_HI = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] SAT_LO = 48'shFFFF_8000_0000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dmm_in_if  in_if ();
  dmm_out_if out_if ();

  dense_matrix_multiply dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // The bench's own copy of the block state. The written flags keep every
  // product away from elements that were never loaded.
  logic [31:0] a_mirror [DIM*DIM];
  logic [31:0] b_mirror [DIM*DIM];
  bit          a_written [DIM*DIM];
  bit          b_written [DIM*DIM];
  logic [3:0]  dim_mirror [3];

  // Elements of C that have been predicted and not yet transferred, oldest first.
  out_item_t   product_q [$];

  int unsigned items_sent;
  bit          tail_quiet;
  int          fail_count;

  // One row of the directed plan: a register write, or an input item whose
  // result is either given by hand or left to the predictor.
  typedef enum logic {STEP_REG, STEP_ITEM} step_kind_e;

  typedef struct {
    step_kind_e kind;
    logic [1:0] reg_idx;
    logic [3:0] reg_val;
    in_item_t   item;
    bit         typed;
    out_item_t  want;
  } plan_step_t;

  plan_step_t plan_q [$];

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", field, want, got);
      fail_count++;
    end
  endfunction

  // A register value of zero acts as one, and values above DIM act as DIM.
  function automatic int unsigned eff_size(logic [3:0] v);
    if (v == 4'd0) begin
      return 1;
    end
    if (v > DIM) begin
      return DIM;
    end
    return v;
  endfunction

  // Works out every element of C from the mirrored stores. Each product is
  // exact in 64 bits. Bits 63:16 of it are the product shifted right by 16
  // with floor rounding, cut to the 48 bits of the accumulator. The 48-bit
  // sum therefore wraps just as the hardware does, and only then
  // saturates to 32 bits.
  function automatic void predict_product();
    int unsigned        nr;
    int unsigned        nk;
    int unsigned        nc;
    logic signed [63:0] prod;
    logic signed [47:0] acc;
    out_item_t          elem;
    nr = eff_size(dim_mirror[REG_ROWS_A]);
    nk = eff_size(dim_mirror[REG_INNER_DIM]);
    nc = eff_size(dim_mirror[REG_COLS_B]);
    for (int unsigned i = 0; i < nr; i++) begin
      for (int unsigned j = 0; j < nc; j++) begin
        acc = '0;
        for (int unsigned k = 0; k < nk; k++) begin
          prod = $signed(a_mirror[i*DIM + k]) * $signed(b_mirror[k*DIM + j]);
          acc  = acc + prod[63:16];
        end
        elem.out_row   = 3'(i);
        elem.out_col   = 3'(j);
        elem.saturated = 1'b1;
        if (acc > SAT_HI) begin
          elem.out_value = 32'h7FFF_FFFF;
        end else if (acc < SAT_LO) begin
          elem.out_value = 32'h8000_0000;
        end else begin
          elem.out_value = acc[31:0];
          elem.saturated = 1'b0;
        end
        elem.last = (i == nr - 1) && (j == nc - 1);
        product_q.push_back(elem);
      end
    end
  endfunction

  function automatic void predict_item(in_item_t it);
    case (it.func)
      FUNC_LOAD_A: begin
        a_mirror[{it.row, it.col}]  = it.value;
        a_written[{it.row, it.col}] = 1'b1;
        items_sent++;
      end
      FUNC_LOAD_B: begin
        b_mirror[{it.row, it.col}]  = it.value;
        b_written[{it.row, it.col}] = 1'b1;
        items_sent++;
      end
      FUNC_MUL: begin
        predict_product();
        items_sent++;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic plan_step_t reg_step(logic [1:0] idx, logic [3:0] val);
    plan_step_t p;
    p.kind    = STEP_REG;
    p.reg_idx = idx;
    p.reg_val = val;
    p.item    = '0;
    p.typed   = 1'b0;
    p.want    = '0;
    return p;
  endfunction

  function automatic plan_step_t item_step(logic [1:0] func, logic [2:0] row,
                                           logic [2:0] col, logic [31:0] value);
    plan_step_t p;
    p.kind       = STEP_ITEM;
    p.reg_idx    = '0;
    p.reg_val    = '0;
    p.item.func  = func;
    p.item.row   = row;
    p.item.col   = col;
    p.item.value = value;
    p.typed      = 1'b0;
    p.want       = '0;
    return p;
  endfunction

  // Product request at 1x1 size, so its single element is written down directly.
  function automatic plan_step_t mul_step(logic [31:0] value, logic sat);
    plan_step_t p;
    p = item_step(FUNC_MUL, 3'd0, 3'd0, 32'd0);
    p.typed          = 1'b1;
    p.want.out_row   = 3'd0;
    p.want.out_col   = 3'd0;
    p.want.out_value = value;
    p.want.saturated = sat;
    p.want.last      = 1'b1;
    return p;
  endfunction

  // Mostly small magnitudes, so that sums keep their meaning. Some values
  // are fully random, and some are the extremes.
  function automatic logic [31:0] pick_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          3: return 32'h0000_0000;
          default: return 32'h0001_0000;
        endcase
      end
      1, 2: return r;
      default: return {{12{r[19]}}, r[19:0]};
    endcase
  endfunction

  function automatic logic [3:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 4'd0;
      1: return 4'd15;
      2: return 4'($urandom_range(9, 15));
      3: return 4'd8;
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  // Presents one item and returns at the edge where it is transferred. The
  // caller drives the valid line again in that same step, either with the
  // next item or low. Nothing else drives it in that step.
  task automatic send_item(input in_item_t it);
    if (!tail_quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  task automatic issue(input in_item_t it);
    send_item(it);
    predict_item(it);
  endtask

  // Stops the sender until every predicted element has been transferred,
  // then lets in-flight loads settle.
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (product_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    // The register takes the data at this edge.
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(input logic [3:0] addr, input logic [3:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field("prdata", {28'd0, want}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes one dimension register and, for a used index, reads it back. A write to the unused
  // index must leave all three registers alone. Later products show
  // whether it did.
  task automatic program_dim(input logic [1:0] idx, input logic [3:0] val);
    apb_write({idx, 2'b00}, {28'd0, val});
    if (idx != REG_UNUSED) begin
      dim_mirror[idx] = val;
      apb_read_check({idx, 2'b00}, val);
    end
  endtask

  // One random job under the current dimensions. It makes a few random
  // writes anywhere in the stores, sometimes a func 3 item, and then loads
  // every element the product still needs. Small products also get about half
  // of their elements refreshed. The job ends with the product request.
  task automatic run_job();
    int unsigned nr;
    int unsigned nk;
    int unsigned nc;
    bit          refresh_ok;
    in_item_t    it;
    nr = eff_size(dim_mirror[REG_ROWS_A]);
    nk = eff_size(dim_mirror[REG_INNER_DIM]);
    nc = eff_size(dim_mirror[REG_COLS_B]);
    refresh_ok = (nr*nk + nk*nc) <= 16;
    repeat ($urandom_range(0, 6)) begin
      it.func  = $urandom_range(0, 1) ? FUNC_LOAD_B : FUNC_LOAD_A;
      it.row   = 3'($urandom);
      it.col   = 3'($urandom);
      it.value = pick_value();
      issue(it);
    end
    if ($urandom_range(0, 5) == 0) begin
      it = in_item_t'({FUNC_NOP, 3'($urandom), 3'($urandom), 32'($urandom)});
      issue(it);
    end
    for (int unsigned r = 0; r < nr; r++) begin
      for (int unsigned k = 0; k < nk; k++) begin
        if (!a_written[r*DIM + k] || (refresh_ok && $urandom_range(0, 1) == 0)) begin
          it = in_item_t'({FUNC_LOAD_A, 3'(r), 3'(k), pick_value()});
          issue(it);
        end
      end
    end
    for (int unsigned k = 0; k < nk; k++) begin
      for (int unsigned c = 0; c < nc; c++) begin
        if (!b_written[k*DIM + c] || (refresh_ok && $urandom_range(0, 1) == 0)) begin
          it = in_item_t'({FUNC_LOAD_B, 3'(k), 3'(c), pick_value()});
          issue(it);
        end
      end
    end
    // The block ignores row, col and value of a product request, so they
    // are random.
    it = in_item_t'({FUNC_MUL, 3'($urandom), 3'($urandom), 32'($urandom)});
    issue(it);
    // Sometimes hold the next item back until the whole product is out.
    if ($urandom_range(0, 5) == 0) begin
      wait_for_results();
    end
  endtask

  // Receiver: ready drops in random bursts, with calm stretches
  // between, and stays high in the last part of the run.
  initial begin : result_sink
    int unsigned pick;
    forever begin
      @(posedge clk_i);
      pick = $urandom_range(0, 15);
      if (tail_quiet || pick > 3) begin
        out_if.ready <= 1'b1;
      end else if (pick == 0) begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(20, 120)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(0, 13)) @(posedge clk_i);
      end
    end
  end

  // Every transfer on the output channel is checked against the oldest
  // predicted element. The values seen are those from before the edge.
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (product_q.size() == 0) begin
        $error("unexpected element row %0d col %0d value %h",
               out_if.payload.out_row, out_if.payload.out_col, out_if.payload.out_value);
        fail_count++;
      end else begin
        want = product_q.pop_front();
        check_field("out_row", want.out_row, out_if.payload.out_row);
        check_field("out_col", want.out_col, out_if.payload.out_col);
        check_field("out_value", want.out_value, out_if.payload.out_value);
        check_field("saturated", want.saturated, out_if.payload.saturated);
        check_field("last", want.last, out_if.payload.last);
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("[dense_matrix_multiply] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [3:0]  dims [3];
    int unsigned phase;

    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    out_if.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    items_sent     = 0;
    tail_quiet     = 1'b0;
    fail_count     = 0;
    for (int unsigned n = 0; n < DIM*DIM; n++) begin
      a_mirror[n]  = '0;
      b_mirror[n]  = '0;
      a_written[n] = 1'b0;
      b_written[n] = 1'b0;
    end
    for (int unsigned n = 0; n < 3; n++) begin
      dim_mirror[n] = DIM_RESET;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All three dimension registers come out of reset at their reset value.
    apb_read_check({REG_ROWS_A, 2'b00}, DIM_RESET);
    apb_read_check({REG_INNER_DIM, 2'b00}, DIM_RESET);
    apb_read_check({REG_COLS_B, 2'b00}, DIM_RESET);

    // Directed plan at 1x1 size. rows_a is set to zero, which must act as
    // one. Each product is then a single element. Up to the last, each can be
    // read off the two values loaded before it.
    plan_q.push_back(reg_step(REG_ROWS_A, 4'd0));
    plan_q.push_back(reg_step(REG_INNER_DIM, 4'd1));
    plan_q.push_back(reg_step(REG_COLS_B, 4'd1));
    plan_q.push_back(reg_step(REG_UNUSED, 4'd5));
    // Largest positive squared: saturates high.
    plan_q.push_back(item_step(FUNC_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF));
    plan_q.push_back(item_step(FUNC_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF));
    plan_q.push_back(mul_step(32'h7FFF_FFFF, 1'b1));
    // Most negative squared: saturates high as well.
    plan_q.push_back(item_step(FUNC_LOAD_A, 3'd0, 3'd0, 32'h8000_0000));
    plan_q.push_back(item_step(FUNC_LOAD_B, 3'd0, 3'd0, 32'h8000_0000));
    plan_q.push_back(mul_step(32'h7FFF_FFFF, 1'b1));
    // Most negative times largest positive: saturates low.
    plan_q.push_back(item_step(FUNC_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF));
    plan_q.push_back(mul_step(32'h8000_0000, 1'b1));
    // -1 LSB times 1 LSB rounds toward minus infinity, to -1 LSB.
    plan_q.push_back(item_step(FUNC_LOAD_A, 3'd0, 3'd0, 32'hFFFF_FFFF));
    plan_q.push_back(item_step(FUNC_LOAD_B, 3'd0, 3'd0, 32'h0000_0001));
    plan_q.push_back(mul_step(32'hFFFF_FFFF, 1'b0));
    // 1.0 times 1.0.
    plan_q.push_back(item_step(FUNC_LOAD_A, 3'd0, 3'd0, 32'h0001_0000));
    plan_q.push_back(item_step(FUNC_LOAD_B, 3'd0, 3'd0, 32'h0001_0000));
    plan_q.push_back(mul_step(32'h0001_0000, 1'b0));
    // A func 3 item aimed at A[0][0] must not touch it.
    plan_q.push_back(item_step(FUNC_NOP, 3'd0, 3'd0, 32'h7FFF_FFFF));
    plan_q.push_back(mul_step(32'h0001_0000, 1'b0));
    // Highest store address. The element is not read here.
    plan_q.push_back(item_step(FUNC_LOAD_B, 3'd7, 3'd7, 32'h8000_0000));
    // Two products of 2^46 add up to 2^47. That wraps the accumulator to
    // its most negative value, which then saturates low.
    plan_q.push_back(reg_step(REG_INNER_DIM, 4'd2));
    plan_q.push_back(item_step(FUNC_LOAD_A, 3'd0, 3'd1, 32'h8000_0000));
    plan_q.push_back(item_step(FUNC_LOAD_A, 3'd0, 3'd0, 32'h8000_0000));
    plan_q.push_back(item_step(FUNC_LOAD_B, 3'd1, 3'd0, 32'h8000_0000));
    plan_q.push_back(item_step(FUNC_LOAD_B, 3'd0, 3'd0, 32'h8000_0000));
    plan_q.push_back(mul_step(32'h8000_0000, 1'b1));

    foreach (plan_q[n]) begin
      if (plan_q[n].kind == STEP_REG) begin
        wait_for_results();
        program_dim(plan_q[n].reg_idx, plan_q[n].reg_val);
      end else begin
        send_item(plan_q[n].item);
        if (plan_q[n].typed) begin
          product_q.push_back(plan_q[n].want);
        end else begin
          predict_item(plan_q[n].item);
        end
      end
    end

    // Random part: each phase drains the block, sets new dimensions and
    // runs a few jobs under them.
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      wait_for_results();
      case (phase)
        0: dims = '{4'd15, 4'd15, 4'd15};
        1: dims = '{4'd0, 4'd0, 4'd0};
        2: dims = '{4'd8, 4'd1, 4'd8};
        3: dims = '{4'd1, 4'd8, 4'd1};
        default: dims = '{pick_dim(), pick_dim(), pick_dim()};
      endcase
      program_dim(REG_ROWS_A, dims[0]);
      program_dim(REG_INNER_DIM, dims[1]);
      program_dim(REG_COLS_B, dims[2]);
      repeat ($urandom_range(1, 3)) begin
        tail_quiet = (items_sent + TAIL_ITEMS >= ITEM_GOAL);
        run_job();
      end
      phase++;
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[dense_matrix_multiply] OK");
    end else begin
      $display("[dense_matrix_multiply] ERROR");
    end
    $finish;
  end

endmodule
